### rtl/ssd_pkg.sv
// Package: widths, parity masks and shared types of the syndrome sync detector.
`default_nettype none
package ssd_pkg;

    localparam int SHIFT_W = 28;
    localparam int TALLY_W = 12;
    localparam int HUND_W  = 19;

    localparam logic [SHIFT_W-1:0] MASK_A = 28'hFB536D3;
    localparam logic [SHIFT_W-1:0] MASK_B = 28'hF7A39E3;
    localparam logic [TALLY_W-1:0] TALLY_TOP = 12'hFFF;

    // configuration register indexes
    localparam logic CFG_MASK_SET_CH0 = 1'b0;
    localparam logic CFG_MASK_SET_CH1 = 1'b1;

    // syndrome bits of one byte: low nibble, then high nibble
    typedef struct packed {
        logic syn_lo;
        logic syn_hi;
    } syn_pair_t;

endpackage
`default_nettype wire

### rtl/ssd_if.sv
// Interfaces: input byte channel and result channel.
`default_nettype none
interface ssd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       channel;
    logic       last_byte;

    modport source (output valid, output data_byte, output channel, output last_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input channel, input last_byte,
                    output ready);
endinterface

interface ssd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        sync_ok;
    logic [ssd_pkg::TALLY_W-1:0] zero_count;
    logic [ssd_pkg::TALLY_W-1:0] one_count;

    modport source (output valid, output sync_ok, output zero_count, output one_count,
                    input ready);
    modport sink   (input valid, input sync_ok, input zero_count, input one_count,
                    output ready);
endinterface
`default_nettype wire

### rtl/ssd_syndrome.sv
// Shift of one byte into the 28-bit history and its two parity syndromes.
`default_nettype none
module ssd_syndrome (
    input  wire logic [ssd_pkg::SHIFT_W-1:0] shift,
    input  wire logic [7:0]                  data_byte,
    input  wire logic                        mask_sel,
    output logic [ssd_pkg::SHIFT_W-1:0]      shift_next,
    output ssd_pkg::syn_pair_t               syn
);

    logic [ssd_pkg::SHIFT_W-1:0] mask;
    logic [ssd_pkg::SHIFT_W-1:0] after_lo;

    always_comb
    begin
        mask       = mask_sel ? ssd_pkg::MASK_B : ssd_pkg::MASK_A;
        after_lo   = {shift[ssd_pkg::SHIFT_W-5:0], data_byte[3:0]};
        shift_next = {shift[ssd_pkg::SHIFT_W-9:0], data_byte[3:0], data_byte[7:4]};
        syn.syn_lo = ^(after_lo & mask);
        syn.syn_hi = ^(shift_next & mask);
    end

endmodule
`default_nettype wire

### rtl/syndrome_sync_detector_core.sv
// Top level: syndrome sync detector with byte input and per-block result output.
// Usage:
//   in_chan  (sink)   : one request per received byte: data_byte, channel, last_byte.
//                       The low nibble is shifted into the history before the high one.
//   out_chan (source) : one request per block, issued for the byte flagged last_byte:
//                       sync_ok, zero_count, one_count (counts saturate at 4095).
//   cfg_we/cfg_index/cfg_data : mask set select per channel (0 = mask A, 1 = mask B).
// Latency: the result is valid in the cycle after the last byte is accepted.
// Throughput: one byte per cycle while in_chan.ready is high; both syndromes, the
//   saturating count update and the ratio test (100*ones <= zeros, zeros nonzero) are
//   formed combinationally in one pass from the history and tally registers.
// Stall: the result sits in the output register; bytes keep being accepted while it
//   is taken in the same cycle. Only when a result is held and the receiver is not
//   ready does in_chan.ready drop.
// Reset: history, tallies, mask sets and the output valid clear; after every last
//   byte the history and tallies clear again for the next block.
`default_nettype none
module syndrome_sync_detector_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic  cfg_index,
    input  wire logic  cfg_data,
    ssd_in_if.sink     in_chan,
    ssd_out_if.source  out_chan
);

    // configuration
    logic mask_set_ch0_reg;
    logic mask_set_ch1_reg;

    // block state
    logic [ssd_pkg::SHIFT_W-1:0] shift_reg, shift_next;
    logic [ssd_pkg::TALLY_W-1:0] zero_tally_reg, zero_tally_next;
    logic [ssd_pkg::TALLY_W-1:0] one_tally_reg, one_tally_next;

    // result register
    logic                        out_valid_reg;
    logic                        sync_ok_reg;
    logic [ssd_pkg::TALLY_W-1:0] zero_count_reg;
    logic [ssd_pkg::TALLY_W-1:0] one_count_reg;

    logic                        accept;
    logic                        mask_sel;
    logic [ssd_pkg::SHIFT_W-1:0] shift_upd;
    ssd_pkg::syn_pair_t          syn;
    logic [1:0]                  n_ones;
    logic [1:0]                  n_zeros;
    logic [ssd_pkg::TALLY_W:0]   zero_sum;
    logic [ssd_pkg::TALLY_W:0]   one_sum;
    logic [ssd_pkg::TALLY_W-1:0] zero_sat;
    logic [ssd_pkg::TALLY_W-1:0] one_sat;
    logic [ssd_pkg::HUND_W-1:0]  ones_x100;
    logic                        sync_ok_calc;

    // output register frees up when empty or being drained
    assign in_chan.ready = !out_valid_reg || out_chan.ready;
    assign accept        = in_chan.valid && in_chan.ready;

    assign mask_sel = in_chan.channel ? mask_set_ch1_reg : mask_set_ch0_reg;

    ssd_syndrome u_syndrome (
        .shift      (shift_reg),
        .data_byte  (in_chan.data_byte),
        .mask_sel   (mask_sel),
        .shift_next (shift_upd),
        .syn        (syn)
    );

    always_comb
    begin
        n_ones    = {1'b0, syn.syn_lo} + {1'b0, syn.syn_hi};
        n_zeros   = 2'd2 - n_ones;
        zero_sum  = {1'b0, zero_tally_reg} + {{(ssd_pkg::TALLY_W-1){1'b0}}, n_zeros};
        one_sum   = {1'b0, one_tally_reg} + {{(ssd_pkg::TALLY_W-1){1'b0}}, n_ones};
        // saturate at the top code
        zero_sat  = zero_sum[ssd_pkg::TALLY_W] ? ssd_pkg::TALLY_TOP
                                               : zero_sum[ssd_pkg::TALLY_W-1:0];
        one_sat   = one_sum[ssd_pkg::TALLY_W] ? ssd_pkg::TALLY_TOP
                                              : one_sum[ssd_pkg::TALLY_W-1:0];
        // 100 = 64 + 32 + 4
        ones_x100 = ({7'd0, one_sat} << 6) + ({7'd0, one_sat} << 5) + ({7'd0, one_sat} << 2);
        sync_ok_calc = (zero_sat != '0) && (ones_x100 <= {7'd0, zero_sat});

        shift_next      = shift_reg;
        zero_tally_next = zero_tally_reg;
        one_tally_next  = one_tally_reg;
        if (accept)
        begin
            if (in_chan.last_byte)
            begin
                shift_next      = '0;
                zero_tally_next = '0;
                one_tally_next  = '0;
            end
            else
            begin
                shift_next      = shift_upd;
                zero_tally_next = zero_sat;
                one_tally_next  = one_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_set_ch0_reg <= 1'b0;
            mask_set_ch1_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ssd_pkg::CFG_MASK_SET_CH0: mask_set_ch0_reg <= cfg_data;
                ssd_pkg::CFG_MASK_SET_CH1: mask_set_ch1_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg      <= '0;
            zero_tally_reg <= '0;
            one_tally_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            shift_reg      <= shift_next;
            zero_tally_reg <= zero_tally_next;
            one_tally_reg  <= one_tally_next;
            if (accept && in_chan.last_byte)
                out_valid_reg <= 1'b1;
            else if (out_chan.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept && in_chan.last_byte)
        begin
            sync_ok_reg    <= sync_ok_calc;
            zero_count_reg <= zero_sat;
            one_count_reg  <= one_sat;
        end
    end

    assign out_chan.valid      = out_valid_reg;
    assign out_chan.sync_ok    = sync_ok_reg;
    assign out_chan.zero_count = zero_count_reg;
    assign out_chan.one_count  = one_count_reg;

    // a last byte always produces a result in the next cycle
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_chan.last_byte |=> out_valid_reg)
        else $error("last byte did not raise result valid");

    // block state is clean after a last byte
    a_clear_after_block: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_chan.last_byte |=>
            shift_reg == '0 && zero_tally_reg == '0 && one_tally_reg == '0)
        else $error("block state not cleared after last byte");

    // a sync verdict needs zero syndromes to be present
    a_sync_needs_zeros: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && sync_ok_reg |-> zero_count_reg != '0)
        else $error("sync reported with no zero syndromes");

    // no byte taken while a held result is stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_chan.ready |-> !accept)
        else $error("byte accepted while result stalled");

endmodule
`default_nettype wire

### sim/syndrome_sync_detector_core_tb.sv
// Testbench: self-checking run of the syndrome sync detector core with random blocks and stalls.
`default_nettype none
module syndrome_sync_detector_core_tb;

    // One block verdict as it leaves the result channel.
    typedef struct packed {
        logic                        sync_ok;
        logic [ssd_pkg::TALLY_W-1:0] zero_count;
        logic [ssd_pkg::TALLY_W-1:0] one_count;
    } verdict_t;

    // Tracks the syndrome history and tallies of the block in progress and keeps
    // the verdicts still owed by the core, oldest first.
    class sync_tracker;
        logic                        mask_sel [2];
        logic [ssd_pkg::SHIFT_W-1:0] history;
        logic [ssd_pkg::TALLY_W-1:0] zeros;
        logic [ssd_pkg::TALLY_W-1:0] ones;
        verdict_t                    verdicts_due [$];
        int                          faults;

        function new();
            mask_sel[0] = 1'b0;
            mask_sel[1] = 1'b0;
            history     = '0;
            zeros       = '0;
            ones        = '0;
            faults      = 0;
        endfunction

        function void flag(string msg);
            if (faults < 10)
            begin
                $display("ERROR: %s", msg);
            end
            faults++;
        endfunction

        // Shift one nibble in, form its syndrome, bump the matching tally (saturating).
        function void shift_nibble(logic [3:0] nib, logic [ssd_pkg::SHIFT_W-1:0] mask);
            history = {history[ssd_pkg::SHIFT_W-5:0], nib};
            if (^(history & mask))
            begin
                if (ones != ssd_pkg::TALLY_TOP)
                begin
                    ones = ones + 1'b1;
                end
            end
            else if (zeros != ssd_pkg::TALLY_TOP)
            begin
                zeros = zeros + 1'b1;
            end
        endfunction

        // Accepted input request: low nibble, then high nibble; verdict on the last byte.
        function void note_byte(logic [7:0] data, logic chan, logic last);
            logic [ssd_pkg::SHIFT_W-1:0] mask;
            verdict_t                    v;
            mask = mask_sel[chan] ? ssd_pkg::MASK_B : ssd_pkg::MASK_A;
            shift_nibble(data[3:0], mask);
            shift_nibble(data[7:4], mask);
            if (last)
            begin
                v.sync_ok    = (zeros != '0) && (100 * int'(ones) <= int'(zeros));
                v.zero_count = zeros;
                v.one_count  = ones;
                verdicts_due.push_back(v);
                history = '0;
                zeros   = '0;
                ones    = '0;
            end
        endfunction

        // Accepted result request: compare with the oldest verdict owed.
        function void check_verdict(logic sync_ok, logic [ssd_pkg::TALLY_W-1:0] zc,
                                    logic [ssd_pkg::TALLY_W-1:0] oc);
            verdict_t want;
            if (verdicts_due.size() == 0)
            begin
                flag($sformatf("unexpected result: sync_ok=%0d zeros=%0d ones=%0d",
                               sync_ok, zc, oc));
                return;
            end
            want = verdicts_due.pop_front();
            if (want.sync_ok !== sync_ok || want.zero_count !== zc || want.one_count !== oc)
            begin
                flag($sformatf({"wrong result: expected sync_ok=%0d zeros=%0d ones=%0d, ",
                                "got sync_ok=%0d zeros=%0d ones=%0d"},
                               want.sync_ok, want.zero_count, want.one_count,
                               sync_ok, zc, oc));
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic cfg_data;

    ssd_in_if  in_chan ();
    ssd_out_if out_chan ();

    sync_tracker tracker = new();

    // Idle odds in percent for the byte sender and the result receiver.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;

    syndrome_sync_detector_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_chan   (in_chan),
        .out_chan  (out_chan)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: ready toggles at random, odds set per phase.
    initial
    begin
        out_chan.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Result monitor: every accepted result request goes to the checker.
    always @(posedge clk)
    begin
        if (rst_n && out_chan.valid && out_chan.ready)
        begin
            tracker.check_verdict(out_chan.sync_ok, out_chan.zero_count, out_chan.one_count);
        end
    end

    // Offer one byte request, with random idle cycles ahead of it, and wait for
    // acceptance. Valid stays high on return so back-to-back requests need no
    // second assignment in the same step.
    task automatic send_byte(input logic [7:0] data, input logic chan, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_chan.valid <= 1'b0;
            @(posedge clk);
        end
        in_chan.valid     <= 1'b1;
        in_chan.data_byte <= data;
        in_chan.channel   <= chan;
        in_chan.last_byte <= last;
        @(posedge clk);
        while (!in_chan.ready)
        begin
            @(posedge clk);
        end
        tracker.note_byte(data, chan, last);
        items_sent++;
    endtask

    // Stop sending and wait until every owed verdict is in, then let the
    // output register settle so the core is truly idle.
    task automatic drain_results();
        in_chan.valid <= 1'b0;
        while (tracker.verdicts_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    // Both mask-set registers, back to back; only called with the core idle.
    task automatic set_masks(input logic m0, input logic m1);
        cfg_we    <= 1'b1;
        cfg_index <= ssd_pkg::CFG_MASK_SET_CH0;
        cfg_data  <= m0;
        @(posedge clk);
        tracker.mask_sel[0] = m0;
        cfg_index <= ssd_pkg::CFG_MASK_SET_CH1;
        cfg_data  <= m1;
        @(posedge clk);
        tracker.mask_sel[1] = m1;
        cfg_we <= 1'b0;
    endtask

    // Long block of one fill byte with a single random byte somewhere inside.
    // Zero fill builds a large zero tally; 0x33 keeps the syndrome at one under
    // either mask set once the history fills, so the one tally dominates.
    task automatic send_long_block(input logic [7:0] fill, input int len);
        int   hot;
        logic chan;
        hot  = $urandom_range(0, len - 1);
        chan = 1'($urandom_range(0, 1));
        for (int i = 0; i < len; i++)
        begin
            send_byte((i == hot) ? 8'($urandom_range(0, 255)) : fill, chan, i == len - 1);
        end
    endtask

    // One random block. Most are short well-formed blocks; some are sparse blocks
    // near the ratio threshold, some use edge byte values, and some never close
    // so their counts roll into the next block.
    task automatic send_random_block();
        int         kind;
        int         len;
        int         hot;
        logic       chan;
        logic [7:0] data;
        kind = $urandom_range(0, 99);
        chan = 1'($urandom_range(0, 1));
        if (kind < 75)
        begin
            // short block, channel may hop between bytes
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    chan = ~chan;
                end
                send_byte(8'($urandom_range(0, 255)), chan, i == len - 1);
            end
        end
        else if (kind < 80)
        begin
            // mostly zero bytes: a lone hot byte gives a handful of ones against
            // about 2*len zeros, so 100*ones lands on both sides of zeros
            len = $urandom_range(30, 200);
            hot = $urandom_range(0, len - 1);
            for (int i = 0; i < len; i++)
            begin
                send_byte((i == hot) ? 8'($urandom_range(1, 255)) : 8'h00, chan, i == len - 1);
            end
        end
        else if (kind < 90)
        begin
            len = $urandom_range(1, 16);
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(0, 4))
                    0:       data = 8'h00;
                    1:       data = 8'hFF;
                    2:       data = 8'h33;
                    3:       data = 8'hF0;
                    default: data = 8'h0F;
                endcase
                send_byte(data, chan, i == len - 1);
            end
        end
        else
        begin
            // no last byte: tallies keep running
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++)
            begin
                send_byte(8'($urandom_range(0, 255)), chan, 1'b0);
            end
        end
    endtask

    initial
    begin
        int target;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= ssd_pkg::CFG_MASK_SET_CH0;
        cfg_data          <= 1'b0;
        in_chan.valid     <= 1'b0;
        in_chan.data_byte <= 8'h00;
        in_chan.channel   <= 1'b0;
        in_chan.last_byte <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part: mask A on both channels first ----
        set_masks(1'b0, 1'b0);
        // single-byte blocks at the byte extremes, both channels
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        // nibble order check
        send_byte(8'h0F, 1'b0, 1'b0);
        send_byte(8'hF0, 1'b0, 1'b0);
        send_byte(8'h5A, 1'b0, 1'b1);
        // channel change inside a block: shared history and tallies
        send_byte(8'h12, 1'b0, 1'b0);
        send_byte(8'h34, 1'b1, 1'b0);
        send_byte(8'h56, 1'b0, 1'b0);
        send_byte(8'h78, 1'b1, 1'b1);
        // history fills completely before the verdict
        for (int i = 0; i < 8; i++)
        begin
            send_byte(8'h33, 1'b1, i == 7);
        end
        // mask change in the middle of an open block
        send_byte(8'hA5, 1'b0, 1'b0);
        send_byte(8'h3C, 1'b1, 1'b0);
        drain_results();
        set_masks(1'b1, 1'b1);
        send_byte(8'hC3, 1'b0, 1'b0);
        send_byte(8'h99, 1'b1, 1'b1);
        // mask B on single low and high bits
        send_byte(8'h01, 1'b0, 1'b1);
        send_byte(8'h80, 1'b1, 1'b1);

        // ---- random part in three idling phases ----
        for (int p = 0; p < 3; p++)
        begin
            drain_results();
            case (p)
                0:
                begin
                    send_idle_pct = 28;
                    recv_idle_pct = 57;
                    set_masks(1'b1, 1'b0);
                end
                1:
                begin
                    send_idle_pct = 57;
                    recv_idle_pct = 28;
                    set_masks(1'b0, 1'b1);
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    set_masks(1'b1, 1'b1);
                end
            endcase
            target = items_sent + 360;
            if (p == 0)
            begin
                send_long_block(8'h00, 200);
            end
            else if (p == 2)
            begin
                send_long_block(8'h33, 200);
            end
            while (items_sent < target)
            begin
                send_random_block();
                // now and then hold the sender until every verdict is in,
                // sometimes with a fresh mask setting after it
                if ($urandom_range(0, 99) < 2)
                begin
                    drain_results();
                    if ($urandom_range(0, 1) == 1)
                    begin
                        set_masks(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    end
                end
            end
        end

        // ---- wind down: all verdicts in, then a few quiet cycles ----
        drain_results();
        repeat (4) @(posedge clk);
        if (tracker.faults == 0)
        begin
            $display("syndrome_sync_detector_core: match");
        end
        else
        begin
            $display("syndrome_sync_detector_core: mismatch");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial
    begin
        #3_000_000;
        $display("syndrome_sync_detector_core: mismatch");
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
rtl/ssd_pkg.sv
rtl/ssd_if.sv
rtl/ssd_syndrome.sv
rtl/syndrome_sync_detector_core.sv
sim/syndrome_sync_detector_core_tb.sv
